// ----- rtl/sorted_matrix_flat_binary_search_core_assert.svh -----
// Assertion macros for the sorted matrix search core
`ifndef SORTED_MATRIX_FLAT_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_MATRIX_FLAT_BINARY_SEARCH_CORE_ASSERT_SVH

// same-cycle implication
`define SMFBS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smfbs: same-cycle check failed");

// next-cycle implication
`define SMFBS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smfbs: next-cycle check failed");

`endif

// ----- rtl/smfbs_pkg.sv -----
// Shared constants, types and codes for the sorted matrix search core
package smfbs_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 11;
   localparam int IDX_W       = 10;
   localparam int POS_W       = 10;
   localparam int PROD_W      = 2 * COUNT_W;
   localparam int DIV_STEP_W  = $clog2(ADDR_W + 1);
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 1'b1;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIZE,
      ST_PROBE,
      ST_CMP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               start;
      logic [ADDR_W-1:0]  dividend;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [ADDR_W-1:0]  quot;
      logic [COUNT_W-1:0] rem;
   } div_rsp_type;

endpackage

// ----- rtl/smfbs_ram.sv -----
// Generic single-port-write, registered-read RAM
module smfbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/smfbs_div.sv -----
// Restoring divider, one quotient bit per cycle: index / cols, index % cols
module smfbs_div
   import smfbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0]     quot_ff, quot_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [COUNT_W-1:0]    divisor_ff, divisor_in;

   logic [COUNT_W:0]      trial;
   logic                  qbit;
   logic [ADDR_W:0]       qshift;

   always_comb begin
      trial  = {rem_ff, quot_ff[ADDR_W-1]};
      qbit   = (trial >= {1'b0, divisor_ff});
      qshift = {quot_ff, qbit};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = DIV_STEP_W'(ADDR_W);
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = qshift[ADDR_W-1:0];
         rem_in  = qbit ? COUNT_W'(trial - {1'b0, divisor_ff}) : trial[COUNT_W-1:0];
         step_in = step_ff - DIV_STEP_W'(1);
         if (step_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

// ----- rtl/sorted_matrix_flat_binary_search_core.sv -----
// Load: written to the element RAM when accepted, no response. Search: setup (ST_SIZE), then
// per probe of the element RAM a registered read (ST_PROBE) and a compare (ST_CMP), at most
// 11 probes over 1024 entries, then the bit-serial divider on a hit or a closing probe on a
// miss, then ST_DONE until the output register is free; one request in flight at a time.
// Synchronous active-high reset clears control state and sets both counts to 1;
// the element RAM is not cleared and holds garbage until loaded.
module sorted_matrix_flat_binary_search_core
   import smfbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [IDX_W-1:0]          req_flat_index,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic [POS_W-1:0]          rsp_row_index,
   output logic [POS_W-1:0]          rsp_col_index,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COUNT_W-1:0]        csr_wdata
);

`include "sorted_matrix_flat_binary_search_core_assert.svh"

   // control
   state_type state_ff, state_in;

   // configuration
   logic [COUNT_W-1:0] row_count_ff, row_count_in;
   logic [COUNT_W-1:0] col_count_ff, col_count_in;

   // search datapath
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]         total_ff, total_in;
   logic [CNT_W-1:0]         lo_ff, lo_in;
   logic [CNT_W-1:0]         hi_ff, hi_in;
   logic [ADDR_W-1:0]        mid_ff, mid_in;
   logic                     res_found_ff, res_found_in;
   logic [POS_W-1:0]         res_row_ff, res_row_in;
   logic [POS_W-1:0]         res_col_ff, res_col_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0] rsp_row_ff, rsp_row_in;
   logic [POS_W-1:0] rsp_col_ff, rsp_col_in;

   // helpers
   logic               req_fire;
   logic               out_free;
   logic [COUNT_W-1:0] eff_rows;
   logic [COUNT_W-1:0] eff_cols;
   logic [PROD_W-1:0]  prod;
   logic [CNT_W:0]     mid_sum;
   logic [CNT_W-1:0]   mid_calc;
   logic               hit;
   logic               below;

   // RAM and divider hookup
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   smfbs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   smfbs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // A count of zero behaves as one.
   assign eff_rows = (row_count_ff == '0) ? COUNT_W'(1) : row_count_ff;
   assign eff_cols = (col_count_ff == '0) ? COUNT_W'(1) : col_count_ff;
   assign prod     = PROD_W'(eff_rows) * PROD_W'(eff_cols);

   // Probe point: lower middle of [lo, hi). Only used while lo < hi.
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - (CNT_W + 1)'(1);
   assign mid_calc = mid_sum[CNT_W:1];

   // Signed compare of the stored word against the target.
   assign hit   = ($signed(ram_rd_data) == key_ff);
   assign below = ($signed(ram_rd_data) < key_ff);

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == KIND_SEARCH)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            state_in = (lo_ff < hi_ff) ? ST_CMP : ST_DONE;
         end
         ST_CMP: begin
            state_in = hit ? ST_DIV : ST_PROBE;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs: handshake, RAM ports, divider start
   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      ram_wr_en        = 1'b0;
      ram_wr_addr      = ADDR_W'(req_flat_index);
      ram_rd_en        = 1'b0;
      ram_rd_addr      = ADDR_W'(mid_calc);
      div_req.start    = 1'b0;
      div_req.dividend = mid_ff;
      div_req.divisor  = eff_cols;
      unique case (state_ff)
         ST_IDLE: begin
            // loads land only while idle, so a probe never meets a write
            ram_wr_en = req_fire && (req_kind == KIND_LOAD) &&
                        (32'(req_flat_index) < STORE_DEPTH);
         end
         ST_PROBE: begin
            ram_rd_en = (lo_ff < hi_ff);
         end
         ST_CMP: begin
            div_req.start = hit;
         end
         ST_SIZE, ST_DIV, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // datapath and configuration
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      key_in       = key_ff;
      total_in     = total_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      res_found_in = res_found_ff;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROW_COUNT:    row_count_in = csr_wdata;
            CSR_COLUMN_COUNT: col_count_in = csr_wdata;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in = req_value;
            end
         end
         ST_SIZE: begin
            // search range saturates at the store depth
            total_in = (prod > PROD_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : CNT_W'(prod);
            lo_in    = '0;
            hi_in    = (prod > PROD_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : CNT_W'(prod);
         end
         ST_PROBE: begin
            mid_in = ADDR_W'(mid_calc);
            if (!(lo_ff < hi_ff)) begin
               res_found_in = 1'b0;
               res_row_in   = '0;
               res_col_in   = '0;
            end
         end
         ST_CMP: begin
            if (!hit) begin
               if (below) begin
                  lo_in = CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  hi_in = CNT_W'(mid_ff);
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_found_in = 1'b1;
               res_row_in   = POS_W'(div_rsp.quot);
               res_col_in   = POS_W'(div_rsp.rem);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_row_in   = res_row_ff;
               rsp_col_in   = res_col_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_count_ff <= COUNT_W'(1);
         col_count_ff <= COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      total_ff     <= total_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      res_found_ff <= res_found_in;
      res_row_ff   <= res_row_in;
      res_col_ff   <= res_col_in;
      rsp_found_ff <= rsp_found_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_col_index = rsp_col_ff;

   // compare stage always follows the read it consumes
   `SMFBS_ASSERT_IMP(a_cmp_after_probe, clock, reset, state_ff == ST_CMP, $past(state_ff) == ST_PROBE)
   // no RAM write while a search is running
   `SMFBS_ASSERT_IMP(a_write_only_idle, clock, reset, ram_wr_en, state_ff == ST_IDLE)
   // search window stays ordered and inside the range
   `SMFBS_ASSERT_IMP(a_window_ok, clock, reset, state_ff == ST_PROBE, (lo_ff <= hi_ff) && (hi_ff <= total_ff))
   // a finished search always shows up at the output register
   `SMFBS_ASSERT_NXT(a_done_to_rsp, clock, reset, (state_ff == ST_DONE) && out_free, rsp_valid_ff)

endmodule
